>>> design/fqr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqr_pkg: shared types and constants
// Entry layout, request/response payloads, operation and status codes, and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fqr_pkg;

   localparam int CAPACITY    = 16;
   localparam int ID_BITS     = 16;
   localparam int HANDLE_BITS = 32;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_POP    = 2'd1,
      FN_REMOVE = 2'd2,
      FN_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH_RD,
      S_SEARCH_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] item_id;
      logic [31:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_id;
      logic [31:0] out_handle;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     id;
      logic [HANDLE_BITS-1:0] hnd;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       ptr_clr;
      logic       ptr_inc;
      logic       rd_en;
      logic       rd_next;
      logic       wr_ins;
      logic       wr_shift;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       capture;
      logic       set_status;
      status_type status_code;
      logic       rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     cnt_zero;
      logic     cnt_full;
      logic     id_match;
      logic     ptr_last;
      logic     next_last;
      logic     rsp_free;
   } stat_type;

endpackage : fqr_pkg
`default_nettype wire

>>> design/fqr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqr_ctrl: operation sequencer
// Steps the datapath through insert, head removal, search and compaction.
// ----------------------------------------------------------------------------
module fqr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fqr_pkg::stat_type stat,
   output fqr_pkg::cmd_type      cmd
);
   import fqr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (stat.func)
               FN_POP, FN_REMOVE: begin
                  state_in = stat.cnt_zero ? S_REPLY : S_SEARCH_RD;
               end
               default: state_in = S_REPLY;
            endcase
         end
         S_SEARCH_RD: state_in = S_SEARCH_CHK;
         S_SEARCH_CHK: begin
            if (stat.func == FN_POP || stat.id_match) begin
               state_in = stat.ptr_last ? S_REPLY : S_SHIFT_RD;
            end else begin
               state_in = stat.ptr_last ? S_REPLY : S_SEARCH_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            state_in = stat.next_last ? S_REPLY : S_SHIFT_RD;
         end
         S_REPLY: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd             = '0;
      cmd.status_code = STAT_OK;
      req_ready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DISPATCH: begin
            unique case (stat.func)
               FN_INSERT: begin
                  if (stat.cnt_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_FULL;
                  end else begin
                     cmd.wr_ins  = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               FN_POP, FN_REMOVE: begin
                  if (stat.cnt_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_EMPTY;
                  end else begin
                     cmd.ptr_clr = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_SEARCH_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_SEARCH_CHK: begin
            if (stat.func == FN_POP || stat.id_match) begin
               cmd.capture = 1'b1;
               cmd.cnt_dec = stat.ptr_last;
            end else if (stat.ptr_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_NOT_FOUND;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_inc  = 1'b1;
            cmd.cnt_dec  = stat.next_last;
         end
         S_REPLY: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: ;
      endcase
   end

endmodule : fqr_ctrl
`default_nettype wire

>>> design/fqr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqr_dpath: entry store, count, scan pointer and response register
// Holds the ordered entries in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
module fqr_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fqr_pkg::req_type  req_payload,
   input  wire fqr_pkg::cmd_type  cmd,
   output fqr_pkg::stat_type      stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fqr_pkg::rsp_type       rsp_payload
);
   import fqr_pkg::*;

   entry_type store [CAPACITY];

   func_type               func_ff;
   logic [ID_BITS-1:0]     key_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [IDX_W-1:0]       ptr_ff;
   entry_type              rd_data_ff;
   entry_type              cap_ff;
   status_type             status_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;
   logic [CNT_W-1:0]       ptr_ext;

   assign ptr_ext = CNT_W'(ptr_ff);
   assign rd_addr = cmd.rd_next ? IDX_W'(ptr_ext + 1'b1) : ptr_ff;
   assign wr_addr = cmd.wr_ins ? cnt_ff[IDX_W-1:0] : ptr_ff;
   assign wr_data = cmd.wr_ins ? entry_type'{id: key_ff, hnd: hnd_ff} : rd_data_ff;

   // entry store
   always_ff @(posedge clock) begin
      if (cmd.wr_ins || cmd.wr_shift) begin
         store[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // request latch, scan pointer, captured entry, status
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff   <= func_type'(req_payload.func);
         key_ff    <= ID_BITS'(req_payload.item_id);
         hnd_ff    <= HANDLE_BITS'(req_payload.entry_handle);
         cap_ff    <= '0;
         status_ff <= STAT_OK;
      end else begin
         if (cmd.capture) cap_ff <= rd_data_ff;
         if (cmd.set_status) status_ff <= cmd.status_code;
      end
      if (cmd.ptr_clr) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= IDX_W'(ptr_ext + 1'b1);
      end
   end

   // count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (cmd.cnt_dec) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = status_ff;
      rsp_in.out_id      = 16'(cap_ff.id);
      rsp_in.out_handle  = 32'(cap_ff.hnd);
      rsp_in.entry_count = 5'(cnt_ff);
      rsp_in.is_empty    = (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      stat.func      = func_ff;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.cnt_full  = (cnt_ff >= CNT_W'(CAPACITY));
      stat.id_match  = (rd_data_ff.id == key_ff);
      stat.ptr_last  = ((ptr_ext + 1'b1) == cnt_ff);
      stat.next_last = ((ptr_ext + 2'd2) == cnt_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule : fqr_dpath
`default_nettype wire

>>> design/fifo_queue_with_remove_by_id.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id: ordered queue with delete by id
// Sequence: insert, no-op and empty/full replies pass through dispatch to the
//   reply state; pop and remove-by-id add a search read and check for each
//   entry scanned and a shift read and write for each entry moved up.
// Requests: one item at a time; the next is taken once the last result is in
//   the response register, and the scan and compaction share the read port.
// Reset: clears the sequencer, entry count and response valid; the entry
//   store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fqr_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fqr_pkg::rsp_type      rsp_payload
);
   import fqr_pkg::*;

   // Commands drive the store, pointer and count; status reports the latched
   // operation, count boundaries, id compare and whether the response slot
   // can take a new transfer.
   cmd_type  cmd;
   stat_type stat;

   // Sequencer: latch the request, dispatch on the operation, walk the
   // entries from the head for a match (pop matches the head at once), then
   // move every later entry up one place and drop the count.
   fqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: entries live in a memory with the head at address zero. The
   // response register lets a finished result wait while the next request
   // is taken.
   fqr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule : fifo_queue_with_remove_by_id
`default_nettype wire
